[rtl/core/assert_macros.svh]
// assertion helpers for the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPL(lbl, clk, rstn, ante, cons)
`define AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/rsidw_pkg.sv]
`default_nettype none
package rsidw_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK_RD, ST_CHK_EV, ST_SRCH_RD, ST_SRCH_EV, ST_SUM_RD, ST_SUM_W,
    ST_SUM_ACC, ST_DIV_PREP, ST_DIV, ST_DONE
  } state_t;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam int unsigned WEIGHT_ONE = 32'd16777216;
  localparam int unsigned FAR_RING = 150;
  localparam int unsigned FAR_SPAN = 30;
endpackage
`default_nettype wire

[rtl/core/ring_search_idw_gap_fill_core.sv]
`default_nettype none
// Raster gap filler. A load word writes one Q16.16 pixel into the on-chip image
// store and returns a zero result. A query word inside the image reads the pixel;
// a valid pixel (above invalid_threshold) is returned as it is. A gap pixel walks
// square rings outward, one store read per ring position, until a ring holds a
// valid pixel, then sums value*w and w over rings e..e+interval with
// w = 2^24/(dx^2+dy^2), taking one shared 32-step restoring divider pass per
// valid term, and ends with one 64-step divide for the rounded mean. The store
// read port and the shared divider set how long a query takes.
// No new word is taken while a query is at work.
module ring_search_idw_gap_fill_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_col,
  input  wire logic [7:0]  in_row,
  input  wire logic signed [31:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_filled_value,
  output logic             out_was_gap,
  output logic             out_found,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rsidw_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;
  // signed coordinates: wide enough for -2*max .. 3*max
  localparam int SW = (CW > RW ? CW : RW) + 4;

  // configuration registers
  logic [8:0]  cols_cfg_r, rows_cfg_r;
  logic [31:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= 9'd256;
      rows_cfg_r <= 9'd256;
      thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: cols_cfg_r <= cfg_data[8:0];
        REG_ROWS: rows_cfg_r <= cfg_data[8:0];
        REG_THRESH: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated image size
  logic signed [SW-1:0] nc, nr, emax;
  always_comb begin
    nc = (cols_cfg_r == 9'd0) ? SW'(1)
       : (int'(cols_cfg_r) > MAX_COLS) ? SW'(MAX_COLS)
       : SW'(cols_cfg_r);
    nr = (rows_cfg_r == 9'd0) ? SW'(1)
       : (int'(rows_cfg_r) > MAX_ROWS) ? SW'(MAX_ROWS)
       : SW'(rows_cfg_r);
    emax = ((nc > nr) ? nc : nr) - SW'(1);
  end

  // image store
  logic [31:0] mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd, mem_q_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  // control and datapath registers
  state_t state_r, state_nxt;
  logic signed [SW-1:0] x_r, y_r, e_r, elast_r, t_r, side_r;
  logic [1:0] seg_r;  // 0 top, 1 bottom, 2 left, 3 right
  logic [63:0] s1_r, s0_r;
  logic [31:0] v_r;
  logic signed [31:0] res_val_r;
  logic res_gap_r, res_found_r, out_valid_r;
  // shared restoring divider
  logic [63:0] dq_r, dd_r;
  logic [64:0] drem_r;
  logic [6:0]  dcnt_r;
  logic        neg_r;

  function automatic logic above(input logic [31:0] a, input logic [31:0] b);
    above = $signed(a) > $signed(b);
  endfunction

  // current ring position from segment and step
  logic signed [SW-1:0] pc, pr;
  logic in_img;
  always_comb begin
    unique case (seg_r)
      2'd0: begin pc = t_r; pr = y_r - e_r; end
      2'd1: begin pc = t_r; pr = y_r + e_r; end
      2'd2: begin pc = x_r - e_r; pr = t_r; end
      default: begin pc = x_r + e_r; pr = t_r; end
    endcase
    in_img = (pc >= 0) && (pc < nc) && (pr >= 0) && (pr < nr);
  end

  // end of the current segment
  logic signed [SW-1:0] seg_end;
  always_comb begin
    seg_end = (seg_r[1]) ? (y_r + e_r - (side_r)) : (x_r + e_r);
  end
  logic step_last;
  assign step_last = (t_r >= seg_end) && seg_r == 2'd3;

  wire in_acc = in_valid && !in_stall;
  wire out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_filled_value = res_val_r;
  assign out_was_gap = res_gap_r;
  assign out_found = res_found_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_acc && in_command == CMD_QUERY) begin
          if ($signed({1'b0, in_col}) < nc && $signed({1'b0, in_row}) < nr)
            state_nxt = ST_CHK_RD;
          else state_nxt = ST_DONE;
        end else if (in_acc) state_nxt = ST_DONE;
      ST_CHK_RD: state_nxt = ST_CHK_EV;
      ST_CHK_EV:
        if (above(mem_q_r, thr_r)) state_nxt = ST_DONE;
        else if (emax < 1) state_nxt = ST_DONE;
        else state_nxt = ST_SRCH_RD;
      ST_SRCH_RD: state_nxt = ST_SRCH_EV;
      ST_SRCH_EV:
        if (in_img && above(mem_q_r, thr_r)) state_nxt = ST_SUM_RD;
        else if (step_last && e_r >= emax) state_nxt = ST_DONE;
        else state_nxt = ST_SRCH_RD;
      ST_SUM_RD: state_nxt = ST_SUM_W;
      ST_SUM_W:
        if (in_img && above(mem_q_r, thr_r)) state_nxt = ST_DIV;
        else if (step_last && e_r >= elast_r) state_nxt = ST_DIV_PREP;
        else state_nxt = ST_SUM_RD;
      ST_DIV:
        if (dcnt_r == 7'd0) state_nxt = (seg_r == 2'd0 && t_r == 0 && e_r == 0)
                                        ? ST_DONE : ST_SUM_ACC;
      ST_SUM_ACC:
        if (step_last && e_r >= elast_r) state_nxt = ST_DIV_PREP;
        else state_nxt = ST_SUM_RD;
      ST_DIV_PREP: state_nxt = ST_DIV;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // store port drive
  always_comb begin
    mem_we = in_acc && in_command == CMD_LOAD &&
             int'(in_col) < MAX_COLS && int'(in_row) < MAX_ROWS;
    mem_wa = {RW'(in_row), CW'(in_col)};
    mem_wd = in_sample;
    mem_ra = (state_r == ST_IDLE) ? {RW'(in_row), CW'(in_col)}
           : (state_r == ST_CHK_RD) ? {y_r[RW-1:0], x_r[CW-1:0]}
           : {pr[RW-1:0], pc[CW-1:0]};
  end

  // d2 for the weight divide, offset along the current segment
  logic signed [SW-1:0] dt;
  logic [31:0] d2;
  always_comb begin
    dt = seg_r[1] ? t_r - y_r : t_r - x_r;
    d2 = 32'(e_r) * 32'(e_r) + 32'(dt) * 32'(dt);
  end

  // weight, weighted term and magnitude of the value sum
  logic [24:0] wt;
  logic signed [57:0] term;
  logic [63:0] s1_mag;
  always_comb begin
    wt = (dq_r[31:0] == 32'd0) ? 25'd1 : dq_r[24:0];
    term = $signed(v_r) * $signed({1'b0, wt});
    s1_mag = s1_r[63] ? 64'd0 - s1_r : s1_r;
  end

  // final divide flag: position cleared to zero marks the mean
  logic final_div_r;

  // next dividend bit: full 64-bit word for the mean, low word for a weight
  logic div_in;
  assign div_in = final_div_r ? dq_r[63] : dq_r[31];

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      final_div_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_acc) begin
          x_r <= SW'(in_col);
          y_r <= SW'(in_row);
          res_val_r <= '0;
          res_gap_r <= 1'b0;
          res_found_r <= 1'b0;
          final_div_r <= 1'b0;
        end
        ST_CHK_EV: begin
          if (above(mem_q_r, thr_r)) begin
            res_val_r <= mem_q_r;
            res_found_r <= 1'b1;
          end else begin
            res_gap_r <= 1'b1;
          end
          e_r <= SW'(1);
          seg_r <= 2'd0;
          side_r <= SW'(1);
          t_r <= x_r - SW'(1);
        end
        ST_SRCH_EV:
          if (in_img && above(mem_q_r, thr_r)) begin
            elast_r <= (e_r > SW'(FAR_RING)) ? e_r + SW'(FAR_SPAN) : e_r + e_r + e_r;
            seg_r <= 2'd0;
            t_r <= x_r - e_r;
            side_r <= SW'(1);
            s1_r <= '0;
            s0_r <= '0;
          end else if (t_r >= seg_end) begin
            if (seg_r == 2'd3) begin
              e_r <= e_r + SW'(1);
              seg_r <= 2'd0;
              t_r <= x_r - e_r - SW'(1);
            end else begin
              seg_r <= seg_r + 2'd1;
              t_r <= (seg_r == 2'd0) ? x_r - e_r : y_r - e_r;
            end
          end else t_r <= t_r + SW'(1);
        ST_SUM_W:
          if (in_img && above(mem_q_r, thr_r)) begin
            v_r <= mem_q_r;
            dd_r <= 64'(d2);
            dq_r <= 64'(WEIGHT_ONE);
            drem_r <= '0;
            dcnt_r <= 7'd32;
          end else begin
            if (t_r >= seg_end) begin
              if (seg_r == 2'd3) begin
                e_r <= e_r + SW'(1);
                seg_r <= 2'd0;
                t_r <= x_r - e_r - SW'(1);
              end else begin
                seg_r <= seg_r + 2'd1;
                t_r <= (seg_r == 2'd0) ? x_r - e_r : y_r - e_r + SW'(1);
              end
            end else t_r <= t_r + SW'(1);
          end
        ST_DIV:
          if (dcnt_r != 7'd0) begin
            // one restoring step: shift in next dividend bit
            if ({drem_r[63:0], div_in} >= {1'b0, dd_r}) begin
              drem_r <= {drem_r[63:0], div_in} - {1'b0, dd_r};
              dq_r <= {dq_r[62:0], 1'b1};
            end else begin
              drem_r <= {drem_r[63:0], div_in};
              dq_r <= {dq_r[62:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 7'd1;
          end else if (final_div_r) begin
            res_val_r <= neg_r ? 32'(64'd0 - dq_r) : dq_r[31:0];
            res_found_r <= 1'b1;
          end
        ST_SUM_ACC: begin
          s1_r <= s1_r + {{6{term[57]}}, term};
          s0_r <= s0_r + {39'd0, wt};
          if (t_r >= seg_end) begin
            if (seg_r == 2'd3) begin
              e_r <= e_r + SW'(1);
              seg_r <= 2'd0;
              t_r <= x_r - e_r - SW'(1);
            end else begin
              seg_r <= seg_r + 2'd1;
              t_r <= (seg_r == 2'd0) ? x_r - e_r : y_r - e_r + SW'(1);
            end
          end else t_r <= t_r + SW'(1);
        end
        ST_DIV_PREP: begin
          neg_r <= s1_r[63];
          dq_r <= {s1_mag[62:0], 1'b0} + s0_r;
          dd_r <= {s0_r[62:0], 1'b0};
          drem_r <= '0;
          dcnt_r <= 7'd64;
          final_div_r <= 1'b1;
          seg_r <= 2'd0; t_r <= '0; e_r <= '0;
        end
        ST_DONE: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  `AST_NEXT(a_done_valid, clk, rst_n, state_r == ST_DONE, out_valid_r)
  `AST_IMPL(a_busy_stall, clk, rst_n, state_r != ST_IDLE, in_stall)
  `AST_IMPL(a_found_gap, clk, rst_n, out_valid_r && out_found && out_was_gap, res_gap_r)
endmodule
`default_nettype wire

[bench/ring_search_idw_gap_fill_core_test.sv]
`default_nettype none
module ring_search_idw_gap_fill_core_test;
  import rsidw_pkg::*;

  localparam int STORE_COLS = 256;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic signed [31:0] value;
    logic               gap;
    logic               hit;
  } fill_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_LOAD;
  logic [7:0] in_col = '0;
  logic [7:0] in_row = '0;
  logic signed [31:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_filled_value;
  logic out_was_gap;
  logic out_found;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_COLS;
  logic [31:0] cfg_data = '0;

  // own copy of the image and registers
  bit [31:0] pixel_mem [0:65535];
  bit        pixel_set [0:65535];
  int        live_cols = 256;
  int        live_rows = 256;
  logic signed [31:0] gap_level = '0;

  fill_result_t pending_fills[$];
  int  fail_count = 0;
  int  words_sent = 0;
  int  queries_sent = 0;
  int  results_seen = 0;
  bit  steady = 1'b0;

  ring_search_idw_gap_fill_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_col(in_col), .in_row(in_row), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filled_value(out_filled_value), .out_was_gap(out_was_gap),
    .out_found(out_found),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // valid pixel inside the active image
  function automatic bit pixel_ok(int c, int r);
    if (c < 0 || c >= live_cols || r < 0 || r >= live_rows) return 1'b0;
    return $signed(pixel_mem[r * STORE_COLS + c]) > gap_level;
  endfunction

  function automatic bit ring_hit(int x, int y, int e);
    for (int t = x - e; t <= x + e; t++)
      if (pixel_ok(t, y - e) || pixel_ok(t, y + e)) return 1'b1;
    for (int t = y - e; t <= y + e; t++)
      if (pixel_ok(x - e, t) || pixel_ok(x + e, t)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void weigh(int c, int r, int e, int dt,
                                inout longint wsum_val, inout longint wsum);
    longint unsigned d2;
    longint unsigned w;
    longint sv;
    if (!pixel_ok(c, r)) return;
    d2 = e * e + dt * dt;
    w = WEIGHT_ONE / d2;
    if (w == 0) w = 1;
    sv = $signed(pixel_mem[r * STORE_COLS + c]);
    wsum_val = wsum_val + sv * longint'(w);
    wsum = wsum + longint'(w);
  endfunction

  // expected result of one word, updating the image for a load
  function automatic fill_result_t fill_pixel(logic cmd, int x, int y,
                                              logic [31:0] s);
    fill_result_t res;
    int e0;
    int span;
    int emax;
    longint wsum_val;
    longint wsum;
    bit neg;
    bit [63:0] mag;
    bit [63:0] q;
    res = '{value: '0, gap: 1'b0, hit: 1'b0};
    wsum_val = 0;
    wsum = 0;
    e0 = 0;
    if (cmd == CMD_LOAD) begin
      pixel_mem[y * STORE_COLS + x] = s;
      pixel_set[y * STORE_COLS + x] = 1'b1;
      return res;
    end
    if (x >= live_cols || y >= live_rows) return res;
    if (pixel_ok(x, y)) begin
      res.value = pixel_mem[y * STORE_COLS + x];
      res.hit = 1'b1;
      return res;
    end
    res.gap = 1'b1;
    emax = (live_cols > live_rows ? live_cols : live_rows) - 1;
    for (int e = 1; e <= emax; e++)
      if (ring_hit(x, y, e)) begin
        e0 = e;
        break;
      end
    if (e0 == 0) return res;
    span = (e0 > FAR_RING) ? FAR_SPAN : 2 * e0;
    for (int e = e0; e <= e0 + span; e++) begin
      for (int t = x - e; t <= x + e; t++) begin
        weigh(t, y - e, e, t - x, wsum_val, wsum);
        weigh(t, y + e, e, t - x, wsum_val, wsum);
      end
      for (int t = y - e + 1; t < y + e; t++) begin
        weigh(x - e, t, e, t - y, wsum_val, wsum);
        weigh(x + e, t, e, t - y, wsum_val, wsum);
      end
    end
    neg = wsum_val < 0;
    mag = neg ? -wsum_val : wsum_val;
    q = (2 * mag + 64'(wsum)) / (2 * 64'(wsum));
    res.value = neg ? -q[31:0] : q[31:0];
    res.hit = 1'b1;
    return res;
  endfunction

  // send one word, then return at the next falling edge
  task automatic send_word(logic cmd, int c, int r, logic [31:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_col <= c[7:0];
    in_row <= r[7:0];
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    pending_fills.push_back(fill_pixel(cmd, c, r, s));
    words_sent++;
    if (cmd == CMD_QUERY) queries_sent++;
    @(negedge clk);
  endtask

  // pause until every word has its result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLS: live_cols = (data[8:0] < 1) ? 1 : (data[8:0] > 256 ? 256 : data[8:0]);
      REG_ROWS: live_rows = (data[8:0] < 1) ? 1 : (data[8:0] > 256 ? 256 : data[8:0]);
      REG_THRESH: gap_level = data;
      default: ;
    endcase
  endtask

  // pixel value: gaps, near-threshold values and full-range words
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return gap_level;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h7fff_ffff;
      default: return gap_level + $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  // new geometry and threshold, then every unwritten active pixel loaded
  task automatic set_geometry(logic [31:0] cols, logic [31:0] rows, logic [31:0] level);
    drain();
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_THRESH, level);
    for (int r = 0; r < live_rows; r++)
      for (int c = 0; c < live_cols; c++)
        if (!pixel_set[r * STORE_COLS + c]) send_word(CMD_LOAD, c, r, pick_value());
  endtask

  task automatic test_directed_small();
    set_geometry(5, 4, 0);
    send_word(CMD_LOAD, 0, 0, 32'h7fff_ffff);
    send_word(CMD_LOAD, 4, 3, 32'h8000_0000);
    send_word(CMD_LOAD, 2, 1, 32'h0000_0000);
    send_word(CMD_LOAD, 1, 1, 32'h0001_0000);
    send_word(CMD_QUERY, 0, 0, 32'hffff_ffff);
    send_word(CMD_QUERY, 1, 1, '0);
    send_word(CMD_QUERY, 4, 3, '0);
    send_word(CMD_QUERY, 2, 1, '0);
    send_word(CMD_QUERY, 5, 0, '0);
    send_word(CMD_QUERY, 0, 4, '0);
    send_word(CMD_QUERY, 255, 255, '0);
    send_word(CMD_LOAD, 255, 255, 32'h1234_5678);
    drain();
    // spare register index does nothing
    write_reg(REG_SPARE, 32'h0000_0001);
    send_word(CMD_QUERY, 2, 1, '0);
    // everything a gap: nothing found
    drain();
    write_reg(REG_THRESH, 32'h7fff_ffff);
    send_word(CMD_QUERY, 3, 2, '0);
    send_word(CMD_QUERY, 0, 0, '0);
    drain();
    write_reg(REG_THRESH, 32'h8000_0000);
    send_word(CMD_QUERY, 4, 3, '0);
    send_word(CMD_QUERY, 2, 1, '0);
  endtask

  // saturated sizes: a short single column, then the widest single row
  task automatic test_strip_extremes();
    set_geometry(0, 12, 32'h8000_0000);
    repeat (12) send_word(CMD_QUERY, $urandom_range(0, 1), $urandom_range(0, 12), '0);
    drain();
    write_reg(REG_COLS, 511);
    write_reg(REG_ROWS, 1);
    send_word(CMD_LOAD, 255, 0, 32'h0001_0000);
    send_word(CMD_QUERY, 255, 0, '0);
    send_word(CMD_QUERY, 255, 1, '0);
    send_word(CMD_QUERY, 0, 1, '0);
  endtask

  task automatic test_random_words();
    int n;
    n = 0;
    while (n < 150) begin
      set_geometry($urandom_range(1, 10), $urandom_range(1, 10),
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      steady = $urandom_range(0, 3) == 0;
      repeat (30) begin
        if ($urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1)) send_word(CMD_LOAD, $urandom_range(0, live_cols - 1),
                                              $urandom_range(0, live_rows - 1), pick_value());
          else send_word(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        end else if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        end else begin
          send_word(CMD_QUERY, $urandom_range(0, live_cols - 1),
                    $urandom_range(0, live_rows - 1), $urandom());
        end
        n++;
      end
      steady = 1'b0;
    end
  endtask

  // result side stall pattern
  initial begin
    int k;
    @(negedge clk);
    forever begin
      k = steady ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
      @(negedge clk);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    fill_result_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_fills.size() == 0) begin
        $error("result word with nothing pending");
        fail_count++;
      end else begin
        exp_word = pending_fills.pop_front();
        if (out_filled_value !== exp_word.value) begin
          $error("filled_value expected %0d actual %0d", exp_word.value, out_filled_value);
          fail_count++;
        end
        if (out_was_gap !== exp_word.gap) begin
          $error("was_gap expected %0d actual %0d", exp_word.gap, out_was_gap);
          fail_count++;
        end
        if (out_found !== exp_word.hit) begin
          $error("found expected %0d actual %0d", exp_word.hit, out_found);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_small();
    test_strip_extremes();
    test_random_words();
    drain();
    repeat (50) @(negedge clk);
    if (pending_fills.size() != 0) fail_count++;
    $display("covered %0d words (%0d queries), %0d results checked",
             words_sent, queries_sent, results_seen);
    $display("saturated single column and single row plus random small images and thresholds");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
